// ===== hw/rtl/ptk_pkg.sv =====
// ptk_pkg: shared types, widths and codes of the per-channel peak tracker.
// Depends on nothing; imported by every tracker module but ptk_ram.
`timescale 1ns / 1ps
package ptk_pkg;

   // payload widths
   localparam int PEAK_W  = 64;
   localparam int ESAT_W  = 32;
   localparam int TOTAL_W = 48;
   localparam int MANT_W  = 32;
   localparam int EXP_W   = 8;
   localparam int VALUE_W = 64;
   localparam int LIDX_W  = 8;
   localparam int HIDX_W  = 8;
   localparam int CIDX_W  = 10;
   localparam int STAT_W  = 2;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int LCNT_W     = 6;
   localparam int HCNT_W     = 4;
   localparam int CCNT_W     = 8;
   // count registers are kept wide enough to hold the largest parameter limit
   localparam int LLIM_W     = 9;
   localparam int HLIM_W     = 9;
   localparam int CLIM_W     = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_COUNT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_RECORDED = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_SCALE    = 2'd2;

   // landing range limits
   localparam logic signed [VALUE_W-1:0] LAND_HI = 64'sd127;
   localparam logic signed [VALUE_W-1:0] LAND_LO = -64'sd127;

   // observation payload held for the update cycle
   typedef struct packed {
      logic signed [VALUE_W-1:0] rotated;
      logic [MANT_W-1:0]         mant;
      logic signed [EXP_W-1:0]   expo;
      logic signed [VALUE_W-1:0] landing;
   } obs_type;

   // decision of the update logic
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [PEAK_W-1:0] peak;
      logic [ESAT_W-1:0] sats;
      logic              sat_flag;
      logic              entry_we;
      logic              scale_we;
      logic              count_obs;
   } upd_type;

endpackage

// ===== hw/rtl/per_channel_peak_tracker_unit.sv =====
// per_channel_peak_tracker_unit: top level of the per-channel peak tracker.
// Depends on ptk_pkg, ptk_ram and ptk_update.
`timescale 1ns / 1ps
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------------
//  request  | req_* fields                            | start high, busy low
//  response | rsp_* fields                            | rsp_valid, one-cycle strobe
//  config   | csr_write_en, csr_index, csr_write_data | write enable, no wait
//
//  In one transaction the accept edge issues the read of the entry memory and the
//  scale memory; the following cycle modifies and writes back and registers the
//  response. Busy interlocks the next read behind the entry memory write-back of
//  this read-modify-write loop, so no new request is taken before it is done.
//  After reset a clearing pass zeroes all 2**(entry address width) entries of the
//  entry memory (32768 with the default parameters), one entry a cycle, busy high.
//  The receiver cannot stall: rsp_valid lasts exactly one cycle.
module per_channel_peak_tracker_unit #(
   parameter int MAX_LAYERS   = 32,
   parameter int MAX_HEADS    = 8,
   parameter int MAX_CHANNELS = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ptk_pkg::LIDX_W-1:0]           req_layer_index,
   input  logic [ptk_pkg::HIDX_W-1:0]           req_head_index,
   input  logic [ptk_pkg::CIDX_W-1:0]           req_channel_index,
   input  logic signed [ptk_pkg::VALUE_W-1:0]   req_rotated_value,
   input  logic [ptk_pkg::MANT_W-1:0]           req_scale_mantissa,
   input  logic signed [ptk_pkg::EXP_W-1:0]     req_scale_exponent,
   input  logic signed [ptk_pkg::VALUE_W-1:0]   req_landing_value,
   // configuration
   input  logic                                 csr_write_en,
   input  logic [ptk_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ptk_pkg::CSR_DATA_W-1:0]       csr_write_data,
   // response
   output logic                                 rsp_valid,
   output logic [ptk_pkg::STAT_W-1:0]           rsp_status,
   output logic [ptk_pkg::PEAK_W-1:0]           rsp_entry_peak,
   output logic [ptk_pkg::ESAT_W-1:0]           rsp_entry_saturations,
   output logic [ptk_pkg::TOTAL_W-1:0]          rsp_total_observations,
   output logic [ptk_pkg::TOTAL_W-1:0]          rsp_total_saturations,
   output logic                                 rsp_landing_saturated
);
   import ptk_pkg::*;

   // index field widths of the entry address
   localparam int LW     = (MAX_LAYERS   > 1) ? $clog2(MAX_LAYERS)   : 1;
   localparam int HW     = (MAX_HEADS    > 1) ? $clog2(MAX_HEADS)    : 1;
   localparam int CW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int AW     = LW + HW + CW;
   localparam int ENT_W  = PEAK_W + ESAT_W;
   localparam int SCL_W  = MANT_W + EXP_W;

   localparam logic [LLIM_W-1:0] LAYER_LIM = LLIM_W'(MAX_LAYERS);
   localparam logic [HLIM_W-1:0] HEAD_LIM  = HLIM_W'(MAX_HEADS);
   localparam logic [CLIM_W-1:0] CHAN_LIM  = CLIM_W'(MAX_CHANNELS);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;

   logic [LLIM_W-1:0]  layer_cnt_ff, layer_cnt_in;
   logic [HLIM_W-1:0]  head_cnt_ff, head_cnt_in;
   logic [CLIM_W-1:0]  chan_cnt_ff, chan_cnt_in;

   logic [2**LW-1:0]   latched_ff, latched_in;
   logic [TOTAL_W-1:0] obs_cnt_ff, obs_cnt_in;
   logic [TOTAL_W-1:0] sat_cnt_ff, sat_cnt_in;

   // transaction held for the update cycle
   logic               in_range_ff, in_range_in;
   logic [LW-1:0]      layer_ff, layer_in;
   logic [AW-1:0]      addr_ff, addr_in;
   obs_type            obs_ff, obs_in;

   // response registers
   logic               rsp_valid_ff, rsp_valid_in;
   upd_type            rsp_ff, rsp_in;

   logic               accept;
   logic               in_range;
   logic [LW-1:0]      rd_layer;
   logic [AW-1:0]      rd_addr;

   logic               ent_we;
   logic [AW-1:0]      ent_waddr;
   logic [ENT_W-1:0]   ent_wdata;
   logic [ENT_W-1:0]   ent_rdata;
   logic [SCL_W-1:0]   scl_rdata;
   upd_type            upd;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // check indices against both the configured count and the parameter limit
   always_comb begin
      in_range = ({1'b0, req_layer_index} < layer_cnt_ff)
              && ({1'b0, req_layer_index} < LAYER_LIM)
              && ({1'b0, req_head_index} < head_cnt_ff)
              && ({1'b0, req_head_index} < HEAD_LIM)
              && ({1'b0, req_channel_index} < chan_cnt_ff)
              && ({1'b0, req_channel_index} < CHAN_LIM);
      rd_layer = req_layer_index[LW-1:0];
      rd_addr  = {req_layer_index[LW-1:0], req_head_index[HW-1:0],
                  req_channel_index[CW-1:0]};
   end

   // entry memory: peak and saturation count side by side
   always_comb begin
      if (state_ff == S_CLEAR) begin
         ent_we    = 1'b1;
         ent_waddr = clr_addr_ff;
         ent_wdata = '0;
      end else begin
         ent_we    = (state_ff == S_EXEC) && upd.entry_we;
         ent_waddr = addr_ff;
         ent_wdata = {upd.peak, upd.sats};
      end
   end

   ptk_ram #(
      .WIDTH  (ENT_W),
      .ADDR_W (AW)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (rd_addr),
      .rd_data (ent_rdata)
   );

   // layer scale memory; the latched flags live in flops so reset clears them
   ptk_ram #(
      .WIDTH  (SCL_W),
      .ADDR_W (LW)
   ) u_scale_ram (
      .clock   (clock),
      .wr_en   ((state_ff == S_EXEC) && upd.scale_we),
      .wr_addr (layer_ff),
      .wr_data ({obs_ff.mant, EXP_W'(obs_ff.expo)}),
      .rd_addr (rd_layer),
      .rd_data (scl_rdata)
   );

   ptk_update u_update (
      .in_range    (in_range_ff),
      .latched     (latched_ff[layer_ff]),
      .stored_mant (scl_rdata[SCL_W-1:EXP_W]),
      .stored_exp  (scl_rdata[EXP_W-1:0]),
      .obs         (obs_ff),
      .old_peak    (ent_rdata[ENT_W-1:ESAT_W]),
      .old_sats    (ent_rdata[ESAT_W-1:0]),
      .upd         (upd)
   );

   // sequencer: clear sweep, then accept / update
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // configuration writes: take them in any state
   always_comb begin
      layer_cnt_in = layer_cnt_ff;
      head_cnt_in  = head_cnt_ff;
      chan_cnt_in  = chan_cnt_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_LAYER_COUNT:   layer_cnt_in = LLIM_W'(csr_write_data[LCNT_W-1:0]);
            CSR_HEAD_COUNT:    head_cnt_in  = HLIM_W'(csr_write_data[HCNT_W-1:0]);
            CSR_CHANNEL_COUNT: chan_cnt_in  = CLIM_W'(csr_write_data[CCNT_W-1:0]);
            default: ;
         endcase
      end
   end

   // latch scale flags and advance saturating totals on write-back
   always_comb begin
      latched_in = latched_ff;
      obs_cnt_in = obs_cnt_ff;
      sat_cnt_in = sat_cnt_ff;
      if (state_ff == S_EXEC) begin
         if (upd.scale_we) begin
            latched_in[layer_ff] = 1'b1;
         end
         if (upd.count_obs && (obs_cnt_ff != '1)) begin
            obs_cnt_in = obs_cnt_ff + TOTAL_W'(1);
         end
         if (upd.sat_flag && (sat_cnt_ff != '1)) begin
            sat_cnt_in = sat_cnt_ff + TOTAL_W'(1);
         end
      end
   end

   // hold the accepted transaction for the update cycle
   always_comb begin
      in_range_in  = in_range_ff;
      layer_in     = layer_ff;
      addr_in      = addr_ff;
      obs_in       = obs_ff;
      if (accept) begin
         in_range_in  = in_range;
         layer_in     = rd_layer;
         addr_in      = rd_addr;
         obs_in       = '{rotated: req_rotated_value, mant: req_scale_mantissa,
                          expo: req_scale_exponent, landing: req_landing_value};
      end
      rsp_valid_in = (state_ff == S_EXEC);
      rsp_in       = (state_ff == S_EXEC) ? upd : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         layer_cnt_ff <= LAYER_LIM;
         head_cnt_ff  <= HEAD_LIM;
         chan_cnt_ff  <= CHAN_LIM;
         latched_ff   <= '0;
         obs_cnt_ff   <= '0;
         sat_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         layer_cnt_ff <= layer_cnt_in;
         head_cnt_ff  <= head_cnt_in;
         chan_cnt_ff  <= chan_cnt_in;
         latched_ff   <= latched_in;
         obs_cnt_ff   <= obs_cnt_in;
         sat_cnt_ff   <= sat_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      in_range_ff <= in_range_in;
      layer_ff    <= layer_in;
      addr_ff     <= addr_in;
      obs_ff      <= obs_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_ff.status;
   assign rsp_entry_peak         = rsp_ff.peak;
   assign rsp_entry_saturations  = rsp_ff.sats;
   assign rsp_landing_saturated  = rsp_ff.sat_flag;
   // totals change only on write-back, so they read straight from the counters
   assign rsp_total_observations = obs_cnt_ff;
   assign rsp_total_saturations  = sat_cnt_ff;

endmodule

// ===== hw/rtl/ptk_ram.sv =====
// ptk_ram: single-port-write, single-port-read synchronous memory, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module ptk_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [2**ADDR_W];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ptk_update.sv =====
// ptk_update: read-modify decision for one observation (peak, saturation, status).
// Depends on ptk_pkg.
`timescale 1ns / 1ps
module ptk_update (
   input  logic                      in_range,
   input  logic                      latched,
   input  logic [ptk_pkg::MANT_W-1:0] stored_mant,
   input  logic [ptk_pkg::EXP_W-1:0]  stored_exp,
   input  ptk_pkg::obs_type          obs,
   input  logic [ptk_pkg::PEAK_W-1:0] old_peak,
   input  logic [ptk_pkg::ESAT_W-1:0] old_sats,
   output ptk_pkg::upd_type          upd
);
   import ptk_pkg::*;

   logic [PEAK_W-1:0] raw;
   logic [PEAK_W-1:0] mag;
   logic              mismatch;
   logic              sat;

   always_comb begin
      raw      = PEAK_W'(obs.rotated);
      mag      = raw[PEAK_W-1] ? (~raw + PEAK_W'(1)) : raw;
      mismatch = latched && ((stored_mant != obs.mant) || (stored_exp != EXP_W'(obs.expo)));
      sat      = (obs.landing > LAND_HI) || (obs.landing < LAND_LO);

      upd = '0;
      if (!in_range) begin
         upd.status = STAT_RANGE;
      end else if (mismatch) begin
         upd.status = STAT_SCALE;
         upd.peak   = old_peak;
         upd.sats   = old_sats;
      end else begin
         upd.status    = STAT_RECORDED;
         upd.peak      = (mag > old_peak) ? mag : old_peak;
         upd.sats      = (sat && (old_sats != '1)) ? old_sats + ESAT_W'(1) : old_sats;
         upd.sat_flag  = sat;
         upd.entry_we  = 1'b1;
         upd.scale_we  = !latched;
         upd.count_obs = 1'b1;
      end
   end

endmodule

// ===== hw/rtl/ptk_checker.sv =====
// ptk_checker: port-level assertions on the peak tracker, bound to the top level.
// Depends on ptk_pkg and per_channel_peak_tracker_unit.
`timescale 1ns / 1ps
module ptk_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [ptk_pkg::STAT_W-1:0]  rsp_status,
   input logic                        rsp_landing_saturated
);
   import ptk_pkg::*;

   // an accepted transaction makes the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accept not followed by busy");

   // every accepted transaction yields its response after the update state
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("missing response after accept");

   // responses never come back to back
   a_rsp_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // a dropped observation never reports a landing saturation
   a_drop_nosat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_RECORDED)) |-> !rsp_landing_saturated)
      else $error("saturation flagged on dropped observation");

endmodule

bind per_channel_peak_tracker_unit ptk_checker u_ptk_checker (
   .clock                 (clock),
   .reset                 (reset),
   .start                 (start),
   .busy                  (busy),
   .rsp_valid             (rsp_valid),
   .rsp_status            (rsp_status),
   .rsp_landing_saturated (rsp_landing_saturated)
);

// ===== dv/tb.sv =====
// tb: self-checking testbench of per_channel_peak_tracker_unit.
// Depends on ptk_pkg and the tracker RTL. It predicts every response and checks
// each field against the prediction.
`timescale 1ns / 1ps
module tb;
   import ptk_pkg::*;

   localparam int N_LAYERS    = 32;
   localparam int N_HEADS     = 8;
   localparam int N_CHANNELS  = 128;
   localparam int ENTRY_DEPTH = N_LAYERS * N_HEADS * N_CHANNELS;

   // one observation as offered on the request channel
   typedef struct packed {
      logic [LIDX_W-1:0]         layer;
      logic [HIDX_W-1:0]         head;
      logic [CIDX_W-1:0]         chan;
      logic signed [VALUE_W-1:0] rotated;
      logic [MANT_W-1:0]         mant;
      logic signed [EXP_W-1:0]   expo;
      logic signed [VALUE_W-1:0] landing;
   } observation_type;

   // one response as the tracker should report it
   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [PEAK_W-1:0]  peak;
      logic [ESAT_W-1:0]  esat;
      logic [TOTAL_W-1:0] obs_total;
      logic [TOTAL_W-1:0] sat_total;
      logic               sat_flag;
   } tracker_result_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [LIDX_W-1:0]         req_layer_index;
   logic [HIDX_W-1:0]         req_head_index;
   logic [CIDX_W-1:0]         req_channel_index;
   logic signed [VALUE_W-1:0] req_rotated_value;
   logic [MANT_W-1:0]         req_scale_mantissa;
   logic signed [EXP_W-1:0]   req_scale_exponent;
   logic signed [VALUE_W-1:0] req_landing_value;
   logic                      csr_write_en;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_write_data;
   logic                      rsp_valid;
   logic [STAT_W-1:0]         rsp_status;
   logic [PEAK_W-1:0]         rsp_entry_peak;
   logic [ESAT_W-1:0]         rsp_entry_saturations;
   logic [TOTAL_W-1:0]        rsp_total_observations;
   logic [TOTAL_W-1:0]        rsp_total_saturations;
   logic                      rsp_landing_saturated;

   per_channel_peak_tracker_unit #(
      .MAX_LAYERS   (N_LAYERS),
      .MAX_HEADS    (N_HEADS),
      .MAX_CHANNELS (N_CHANNELS)
   ) dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_layer_index        (req_layer_index),
      .req_head_index         (req_head_index),
      .req_channel_index      (req_channel_index),
      .req_rotated_value      (req_rotated_value),
      .req_scale_mantissa     (req_scale_mantissa),
      .req_scale_exponent     (req_scale_exponent),
      .req_landing_value      (req_landing_value),
      .csr_write_en           (csr_write_en),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .rsp_valid              (rsp_valid),
      .rsp_status             (rsp_status),
      .rsp_entry_peak         (rsp_entry_peak),
      .rsp_entry_saturations  (rsp_entry_saturations),
      .rsp_total_observations (rsp_total_observations),
      .rsp_total_saturations  (rsp_total_saturations),
      .rsp_landing_saturated  (rsp_landing_saturated)
   );

   // ---------------------------------------------------------------------------
   // Tracker state as the testbench sees it: counts, per-layer scales, entry
   // peaks and saturation counts, and the two global counters.
   // ---------------------------------------------------------------------------
   logic [LCNT_W-1:0]  layer_cnt;
   logic [HCNT_W-1:0]  head_cnt;
   logic [CCNT_W-1:0]  chan_cnt;
   logic [PEAK_W-1:0]  peak_mem  [0:ENTRY_DEPTH-1];
   logic [ESAT_W-1:0]  esat_mem  [0:ENTRY_DEPTH-1];
   logic               scale_set [0:N_LAYERS-1];
   logic [MANT_W-1:0]  scale_mant [0:N_LAYERS-1];
   logic [EXP_W-1:0]   scale_expo [0:N_LAYERS-1];
   logic [TOTAL_W-1:0] obs_count;
   logic [TOTAL_W-1:0] sat_count;

   tracker_result_type pending_results[$];
   tracker_result_type head_result;
   int                 errors;
   logic               idle_enable;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: the clearing pass after reset plus all traffic fits inside this,
   // even under the longest idles.
   initial begin
      #(3_000_000);
      $display("FAIL");
      $finish;
   end

   function automatic void clear_tracker_model();
      layer_cnt = LCNT_W'(N_LAYERS);
      head_cnt  = HCNT_W'(N_HEADS);
      chan_cnt  = CCNT_W'(N_CHANNELS);
      for (int i = 0; i < ENTRY_DEPTH; i++) begin
         peak_mem[i] = '0;
         esat_mem[i] = '0;
      end
      for (int i = 0; i < N_LAYERS; i++) begin
         scale_set[i]  = 1'b0;
         scale_mant[i] = '0;
         scale_expo[i] = '0;
      end
      obs_count = '0;
      sat_count = '0;
   endfunction

   // Apply one accepted observation to the tracker state and return the
   // response it must produce.
   function automatic tracker_result_type track_observation(input observation_type o);
      tracker_result_type r;
      logic [14:0]        slot;
      logic [PEAK_W-1:0]  mag;
      logic               sat;
      r = '0;
      // drop anything at or past its count or the parameter limit
      if (o.layer >= layer_cnt || o.layer >= N_LAYERS ||
          o.head >= head_cnt || o.head >= N_HEADS ||
          o.chan >= chan_cnt || o.chan >= N_CHANNELS) begin
         r.status    = STAT_RANGE;
         r.obs_total = obs_count;
         r.sat_total = sat_count;
         return r;
      end
      slot = {o.layer[4:0], o.head[2:0], o.chan[6:0]};
      if (!scale_set[o.layer[4:0]]) begin
         scale_set[o.layer[4:0]]  = 1'b1;
         scale_mant[o.layer[4:0]] = o.mant;
         scale_expo[o.layer[4:0]] = o.expo;
      end else if (scale_mant[o.layer[4:0]] != o.mant ||
                   scale_expo[o.layer[4:0]] != o.expo) begin
         r.status    = STAT_SCALE;
         r.peak      = peak_mem[slot];
         r.esat      = esat_mem[slot];
         r.obs_total = obs_count;
         r.sat_total = sat_count;
         return r;
      end
      // two's complement magnitude; the most negative value yields 2**63
      mag = o.rotated[VALUE_W-1] ? (~o.rotated + 64'd1) : o.rotated;
      if (mag > peak_mem[slot])
         peak_mem[slot] = mag;
      if (obs_count != {TOTAL_W{1'b1}})
         obs_count = obs_count + TOTAL_W'(1);
      sat = ($signed(o.landing) > LAND_HI) || ($signed(o.landing) < LAND_LO);
      if (sat) begin
         if (sat_count != {TOTAL_W{1'b1}})
            sat_count = sat_count + TOTAL_W'(1);
         if (esat_mem[slot] != {ESAT_W{1'b1}})
            esat_mem[slot] = esat_mem[slot] + ESAT_W'(1);
      end
      r.status    = STAT_RECORDED;
      r.peak      = peak_mem[slot];
      r.esat      = esat_mem[slot];
      r.obs_total = obs_count;
      r.sat_total = sat_count;
      r.sat_flag  = sat;
      return r;
   endfunction

   function automatic observation_type make_obs(input int unsigned layer, head, chan,
                                                input logic [63:0] rotated,
                                                input logic [31:0] mant,
                                                input logic [7:0] expo,
                                                input logic [63:0] landing);
      observation_type o;
      o.layer   = LIDX_W'(layer);
      o.head    = HIDX_W'(head);
      o.chan    = CIDX_W'(chan);
      o.rotated = rotated;
      o.mant    = mant;
      o.expo    = expo;
      o.landing = landing;
      return o;
   endfunction

   // Count register data with random bits above the register width, so every
   // write data bit toggles while the register keeps its low bits only.
   function automatic logic [CSR_DATA_W-1:0] upper_noise(input int count, input int bits);
      logic [CSR_DATA_W-1:0] m;
      m = (CSR_DATA_W'(1) << bits) - CSR_DATA_W'(1);
      return (CSR_DATA_W'($urandom()) & ~m) | (CSR_DATA_W'(count) & m);
   endfunction

   // Random observation: mostly well-formed (in range, matching scale) with
   // random content, some concentrated on a few entries so peaks and counts
   // build up; the rest is index noise and scale mismatches.
   function automatic observation_type rand_obs();
      observation_type o;
      int              lim_l, lim_h, lim_c;
      int              tmp;
      int unsigned     sel;
      lim_l = (layer_cnt < N_LAYERS)  ? layer_cnt : N_LAYERS;
      lim_h = (head_cnt < N_HEADS)    ? head_cnt  : N_HEADS;
      lim_c = (chan_cnt < N_CHANNELS) ? chan_cnt  : N_CHANNELS;
      o.layer = LIDX_W'($urandom_range(0, 255));
      o.head  = HIDX_W'($urandom_range(0, 255));
      o.chan  = CIDX_W'($urandom_range(0, 1023));
      o.mant  = $urandom();
      o.expo  = EXP_W'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 80 && lim_l > 0 && lim_h > 0 && lim_c > 0) begin
         if ($urandom_range(0, 1) == 1) begin
            o.layer = LIDX_W'($urandom_range(0, ((lim_l < 2) ? lim_l : 2) - 1));
            o.head  = HIDX_W'($urandom_range(0, ((lim_h < 2) ? lim_h : 2) - 1));
            o.chan  = CIDX_W'($urandom_range(0, ((lim_c < 3) ? lim_c : 3) - 1));
         end else begin
            o.layer = LIDX_W'($urandom_range(0, lim_l - 1));
            o.head  = HIDX_W'($urandom_range(0, lim_h - 1));
            o.chan  = CIDX_W'($urandom_range(0, lim_c - 1));
         end
         if (scale_set[o.layer[4:0]]) begin
            sel = $urandom_range(0, 99);
            if (sel < 94)
               o.mant = scale_mant[o.layer[4:0]];
            if (sel < 88)
               o.expo = scale_expo[o.layer[4:0]];
         end
      end
      case ($urandom_range(0, 3))
         0: o.rotated = {$urandom(), $urandom()};
         1: begin
            tmp = int'($urandom_range(0, 65535)) - 32768;
            o.rotated = VALUE_W'(tmp);
         end
         2: begin
            o.rotated = {$urandom(), $urandom()} >> $urandom_range(0, 63);
            if ($urandom_range(0, 1) == 1)
               o.rotated = -o.rotated;
         end
         default: begin
            case ($urandom_range(0, 3))
               0: o.rotated = {1'b1, 63'd0};
               1: o.rotated = {1'b0, {63{1'b1}}};
               2: o.rotated = '0;
               default: o.rotated = '1;
            endcase
         end
      endcase
      case ($urandom_range(0, 3))
         0: begin
            tmp = int'($urandom_range(0, 254)) - 127;
            o.landing = VALUE_W'(tmp);
         end
         1: begin
            case ($urandom_range(0, 3))
               0: tmp = 127;
               1: tmp = 128;
               2: tmp = -127;
               default: tmp = -128;
            endcase
            o.landing = VALUE_W'(tmp);
         end
         2: begin
            tmp = int'($urandom_range(0, 1000)) - 500;
            o.landing = VALUE_W'(tmp);
         end
         default: o.landing = {$urandom(), $urandom()};
      endcase
      return o;
   endfunction

   // Offer one observation and hold it until the tracker accepts it; predict
   // the response at the accepting edge. Start stays high afterwards so that
   // back-to-back transactions need no extra NBA.
   task automatic send_obs(input observation_type o);
      if (idle_enable && $urandom_range(0, 99) < 17) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start              <= 1'b1;
      req_layer_index    <= o.layer;
      req_head_index     <= o.head;
      req_channel_index  <= o.chan;
      req_rotated_value  <= o.rotated;
      req_scale_mantissa <= o.mant;
      req_scale_exponent <= o.expo;
      req_landing_value  <= o.landing;
      do @(posedge clock); while (busy);
      pending_results.insert(pending_results.size(), track_observation(o));
   endtask

   // Drop start and hold until every predicted response has been checked.
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Write all three count registers back to back; only call when drained.
   task automatic write_counts(input logic [CSR_DATA_W-1:0] l_data, h_data, c_data);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_LAYER_COUNT;
      csr_write_data <= l_data;
      @(posedge clock);
      layer_cnt = l_data[LCNT_W-1:0];
      csr_index      <= CSR_HEAD_COUNT;
      csr_write_data <= h_data;
      @(posedge clock);
      head_cnt = h_data[HCNT_W-1:0];
      csr_index      <= CSR_CHANNEL_COUNT;
      csr_write_data <= c_data;
      @(posedge clock);
      chan_cnt = c_data[CCNT_W-1:0];
      csr_write_en   <= 1'b0;
   endtask

   // Peak and landing extremes at the default counts, corner entries included.
   task automatic test_extremes();
      send_obs(make_obs(0, 0, 0, {1'b1, 63'd0}, 32'd0, 8'd0, 64'sd127));
      send_obs(make_obs(0, 0, 0, {1'b0, {63{1'b1}}}, 32'd0, 8'd0, 64'sd128));
      send_obs(make_obs(31, 7, 127, 64'd0, 32'hFFFF_FFFF, 8'h80, -64'sd127));
      send_obs(make_obs(31, 7, 127, '1, 32'hFFFF_FFFF, 8'h80, -64'sd128));
      send_obs(make_obs(31, 7, 127, 64'd5, 32'hFFFF_FFFF, 8'h80, {1'b1, 63'd0}));
      send_obs(make_obs(31, 7, 127, 64'd3, 32'hFFFF_FFFF, 8'h80, {1'b0, {63{1'b1}}}));
   endtask

   // Each index exactly at its limit, and every index at its field maximum.
   task automatic test_index_range();
      send_obs(make_obs(32, 0, 0, 64'd9, 32'd0, 8'd0, 64'd0));
      send_obs(make_obs(0, 8, 0, 64'd9, 32'd0, 8'd0, 64'd0));
      send_obs(make_obs(0, 0, 128, 64'd9, 32'd0, 8'd0, 64'd0));
      send_obs(make_obs(255, 255, 1023, '1, '1, '1, '1));
   endtask

   // First scale latches; a different mantissa or exponent is dropped.
   task automatic test_scale_latch();
      send_obs(make_obs(5, 0, 0, 64'd1000, 32'h1234_5678, 8'd3, 64'sd200));
      send_obs(make_obs(5, 1, 0, 64'd7, 32'h1234_5679, 8'd3, 64'd0));
      send_obs(make_obs(5, 0, 0, 64'd9999, 32'h1234_5678, 8'd4, 64'sd300));
      send_obs(make_obs(5, 0, 0, -64'sd2000, 32'h1234_5678, 8'd3, 64'd0));
   endtask

   // Small counts, counts above the parameter limits, and zero counts.
   task automatic test_count_registers();
      wait_drained();
      write_counts(upper_noise(3, LCNT_W), upper_noise(2, HCNT_W), CSR_DATA_W'(5));
      send_obs(make_obs(2, 1, 4, 64'd11, 32'hA5A5_0001, 8'd1, 64'd0));
      send_obs(make_obs(3, 0, 0, 64'd11, 32'd0, 8'd0, 64'd0));
      send_obs(make_obs(0, 2, 0, 64'd11, 32'd0, 8'd0, 64'd0));
      send_obs(make_obs(0, 0, 5, 64'd11, 32'd0, 8'd0, 64'd0));
      wait_drained();
      write_counts('1, '1, '1);
      send_obs(make_obs(31, 7, 127, 64'd77, 32'hFFFF_FFFF, 8'h80, 64'd0));
      send_obs(make_obs(32, 0, 0, 64'd77, 32'd0, 8'd0, 64'd0));
      wait_drained();
      write_counts('0, '0, '0);
      send_obs(make_obs(0, 0, 0, 64'd1, 32'd0, 8'd0, 64'd0));
   endtask

   // Random traffic in phases, each under its own count setting. One phase
   // runs with no idling at all; another pauses mid-way until drained.
   task automatic test_random_traffic();
      int n_items;
      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         n_items = 170;
         idle_enable = 1'b1;
         case (ph)
            0: write_counts(upper_noise(N_LAYERS, LCNT_W), upper_noise(N_HEADS, HCNT_W),
                            CSR_DATA_W'(N_CHANNELS));
            1: write_counts('1, '1, '1);
            2: begin
               write_counts(upper_noise(2, LCNT_W), upper_noise(1, HCNT_W),
                            CSR_DATA_W'(3));
               n_items = 150;
            end
            3: begin
               write_counts(upper_noise($urandom_range(1, 40), LCNT_W),
                            upper_noise($urandom_range(1, 10), HCNT_W),
                            CSR_DATA_W'($urandom_range(1, 140)));
               n_items = 180;
               idle_enable = 1'b0;
            end
            4: begin
               write_counts('0, '0, '0);
               n_items = 30;
            end
            default: begin
               write_counts(upper_noise($urandom_range(1, 63), LCNT_W),
                            upper_noise($urandom_range(1, 15), HCNT_W),
                            CSR_DATA_W'($urandom_range(1, 255)));
               n_items = 200;
            end
         endcase
         for (int i = 0; i < n_items; i++) begin
            if (ph == 5 && i == 100)
               wait_drained();
            send_obs(rand_obs());
         end
      end
      idle_enable = 1'b1;
   endtask

   // Compare one response field; report and count any difference.
   function automatic void check_field(input string name, input logic [63:0] exp_v,
                                       input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endfunction

   // Response checker: every strobe must match the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("response with no transaction outstanding");
            errors++;
         end else begin
            head_result = pending_results.pop_front();
            check_field("status", 64'(head_result.status), 64'(rsp_status));
            check_field("entry_peak", head_result.peak, rsp_entry_peak);
            check_field("entry_saturations", 64'(head_result.esat),
                        64'(rsp_entry_saturations));
            check_field("total_observations", 64'(head_result.obs_total),
                        64'(rsp_total_observations));
            check_field("total_saturations", 64'(head_result.sat_total),
                        64'(rsp_total_saturations));
            check_field("landing_saturated", 64'(head_result.sat_flag),
                        64'(rsp_landing_saturated));
         end
      end
   end

   initial begin
      errors             = 0;
      idle_enable        = 1'b1;
      reset              = 1'b1;
      start              = 1'b0;
      req_layer_index    = '0;
      req_head_index     = '0;
      req_channel_index  = '0;
      req_rotated_value  = '0;
      req_scale_mantissa = '0;
      req_scale_exponent = '0;
      req_landing_value  = '0;
      csr_write_en       = 1'b0;
      csr_index          = CSR_LAYER_COUNT;
      csr_write_data     = '0;
      clear_tracker_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // the clearing pass keeps busy high; the first send simply waits it out
      test_extremes();
      test_index_range();
      test_scale_latch();
      test_count_registers();
      test_random_traffic();
      wait_drained();
      // allow for a stray response after the last expected one
      repeat (8) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== per_channel_peak_tracker_unit.f =====
hw/rtl/ptk_pkg.sv
hw/rtl/ptk_ram.sv
hw/rtl/ptk_update.sv
hw/rtl/per_channel_peak_tracker_unit.sv
hw/rtl/ptk_checker.sv
dv/tb.sv
